>>> rtl/command_line_deframer_defines.svh
// Assertion helpers for the command line deframer.
`ifndef COMMAND_LINE_DEFRAMER_DEFINES_SVH
`define COMMAND_LINE_DEFRAMER_DEFINES_SVH

// Condition that holds at every clock edge outside reset.
`define CLD_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Condition that implies another in the same cycle.
`define CLD_ASSERT_IMPLY(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

`endif

>>> rtl/cld_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cld_pkg;

    localparam int ADDR_W = 4;

    localparam logic [ADDR_W-1:0] REG_STREAMING = 4'h0;
    localparam logic [ADDR_W-1:0] REG_SETTINGS  = 4'h4;
    localparam logic [ADDR_W-1:0] REG_CONFIG    = 4'h8;

    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_ACK  = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_S  = 8'h73;
    localparam logic [7:0] CH_E  = 8'h65;
    localparam logic [7:0] CH_T  = 8'h74;
    localparam logic [7:0] CH_C  = 8'h63;

    localparam logic [15:0] SETS_EXTRA = 16'd6;
    localparam logic [15:0] SETC_EXTRA = 16'd7;

    localparam logic [7:0] SIZE_RESET = 8'd64;
    localparam logic [7:0] QUEUE_MAX  = 8'd255;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic [1:0] read_slot;
        logic [7:0] read_position;
    } cmd_t;

    typedef struct packed {
        logic [1:0] slot;
        logic [7:0] position;
        logic       line_complete;
        logic [7:0] line_length;
        logic       echo_line;
        logic [7:0] pending_lines;
        logic       ready_out;
        logic [7:0] read_data;
    } rsp_t;

    // Per-slot summary of the first four stored bytes of a line.
    typedef struct packed {
        logic s0;
        logic e1;
        logic t2;
        logic s3;
        logic c3;
    } hdr_t;

endpackage

`default_nettype wire

>>> rtl/cld_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module cld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/command_line_deframer.sv
// Latency: an accepted item's result is registered and appears on rsp in the next cycle.
// Throughput: one item per cycle while cmd is not stalled; the line store is split into even
// and odd position banks so a byte and its appended CR are written in the same cycle.
// Reset: state clears at once, then a clearing pass zeroes every address of both
// line store banks with cmd stalled.
`timescale 1ns / 1ps
`default_nettype none
`include "command_line_deframer_defines.svh"

module command_line_deframer #(
    parameter int LINE_BYTES = 128,
    parameter int SLOT_COUNT = 4
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cmd_valid,
    output logic                           cmd_stall,
    input  wire cld_pkg::cmd_t             cmd,
    output logic                           rsp_valid,
    input  wire logic                      rsp_stall,
    output cld_pkg::rsp_t                  rsp,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [cld_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]               pwdata,
    output logic      [31:0]               prdata,
    output logic                           pready
);

    import cld_pkg::*;

    localparam int POS_W   = $clog2(LINE_BYTES + 1);
    localparam int SLOT_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int BANK_AW = SLOT_W + POS_W - 1;
    localparam int BANK_D  = 1 << BANK_AW;

    // Configuration registers
    logic       streaming_mode_reg;
    logic [7:0] settings_size_reg;
    logic [7:0] config_size_reg;
    logic       cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            streaming_mode_reg <= 1'b0;
            settings_size_reg  <= SIZE_RESET;
            config_size_reg    <= SIZE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr)
                REG_STREAMING: streaming_mode_reg <= pwdata[0];
                REG_SETTINGS:  settings_size_reg  <= pwdata[7:0];
                REG_CONFIG:    config_size_reg    <= pwdata[7:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr)
            REG_STREAMING: prdata = {31'd0, streaming_mode_reg};
            REG_SETTINGS:  prdata = {24'd0, settings_size_reg};
            REG_CONFIG:    prdata = {24'd0, config_size_reg};
            default:       prdata = 32'd0;
        endcase
    end

    // Clearing pass
    logic               clearing_reg;
    logic [BANK_AW-1:0] clr_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clr_addr_reg <= clr_addr_reg + BANK_AW'(1);
            if (clr_addr_reg == BANK_AW'(BANK_D - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // Line state
    logic [SLOT_W-1:0] write_slot_reg, write_slot_next;
    logic [POS_W-1:0]  write_index_reg, write_index_next;
    logic              ready_flag_reg, ready_flag_next;
    logic [7:0]        queue_count_reg, queue_count_next;
    hdr_t              hdr_reg [SLOT_COUNT];
    hdr_t              hdr_slot_next;

    logic cmd_accept;
    logic is_byte;
    logic is_read;

    assign cmd_stall  = clearing_reg || (rsp_valid && rsp_stall);
    assign cmd_accept = cmd_valid && !cmd_stall;
    assign is_byte    = cmd.kind == KIND_BYTE;
    assign is_read    = cmd.kind == KIND_READ;

    hdr_t           eff_hdr;
    logic [POS_W:0] idx_inc;
    logic [POS_W:0] line_len;
    logic           is_term;
    logic           hdr_set;
    logic           stop;
    logic           overflow;
    logic           close;
    logic           echo;
    logic           append;

    always_comb
    begin
        eff_hdr = hdr_reg[write_slot_reg];
        // Fold the byte being written into the header summary.
        if (write_index_reg == POS_W'(0))
        begin
            eff_hdr.s0 = cmd.data_byte == CH_S;
        end
        else if (write_index_reg == POS_W'(1))
        begin
            eff_hdr.e1 = cmd.data_byte == CH_E;
        end
        else if (write_index_reg == POS_W'(2))
        begin
            eff_hdr.t2 = cmd.data_byte == CH_T;
        end
        else if (write_index_reg == POS_W'(3))
        begin
            eff_hdr.s3 = cmd.data_byte == CH_S;
            eff_hdr.c3 = cmd.data_byte == CH_C;
        end

        idx_inc  = {1'b0, write_index_reg} + (POS_W + 1)'(1);
        is_term  = (cmd.data_byte == CH_CR) || (cmd.data_byte == CH_LF);
        hdr_set  = eff_hdr.s0 && eff_hdr.e1 && eff_hdr.t2;
        stop     = is_term && (!hdr_set
                   || (eff_hdr.s3 && (16'(idx_inc) >= 16'(settings_size_reg) + SETS_EXTRA))
                   || (eff_hdr.c3 && (16'(idx_inc) >= 16'(config_size_reg) + SETC_EXTRA)));
        overflow = 16'(idx_inc) > 16'(LINE_BYTES);
        close    = overflow || stop;
        echo     = close && !ready_flag_reg && !streaming_mode_reg;
        append   = echo && (16'(idx_inc) < 16'(LINE_BYTES));
        line_len = idx_inc + (POS_W + 1)'(append);

        // An appended CR inside the header spoils the match.
        hdr_slot_next = eff_hdr;
        if (append)
        begin
            if (idx_inc == (POS_W + 1)'(1))
            begin
                hdr_slot_next.e1 = 1'b0;
            end
            else if (idx_inc == (POS_W + 1)'(2))
            begin
                hdr_slot_next.t2 = 1'b0;
            end
            else if (idx_inc == (POS_W + 1)'(3))
            begin
                hdr_slot_next.s3 = 1'b0;
                hdr_slot_next.c3 = 1'b0;
            end
        end
    end

    always_comb
    begin
        write_slot_next  = write_slot_reg;
        write_index_next = write_index_reg;
        ready_flag_next  = ready_flag_reg;
        queue_count_next = queue_count_reg;
        case (cmd.kind)
            KIND_BYTE:
            begin
                if (close)
                begin
                    write_index_next = '0;
                    write_slot_next  = (write_slot_reg == SLOT_W'(SLOT_COUNT - 1))
                                       ? '0 : write_slot_reg + SLOT_W'(1);
                    ready_flag_next  = 1'b1;
                    if (queue_count_reg != QUEUE_MAX)
                    begin
                        queue_count_next = queue_count_reg + 8'd1;
                    end
                end
                else
                begin
                    write_index_next = idx_inc[POS_W-1:0];
                end
            end
            KIND_ACK:
            begin
                ready_flag_next = 1'b0;
                if (queue_count_reg != 8'd0)
                begin
                    queue_count_next = queue_count_reg - 8'd1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_slot_reg  <= '0;
            write_index_reg <= '0;
            ready_flag_reg  <= 1'b0;
            queue_count_reg <= '0;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                hdr_reg[i] <= '0;
            end
        end
        else if (cmd_accept)
        begin
            write_slot_reg  <= write_slot_next;
            write_index_reg <= write_index_next;
            ready_flag_reg  <= ready_flag_next;
            queue_count_reg <= queue_count_next;
            if (is_byte)
            begin
                hdr_reg[write_slot_reg] <= hdr_slot_next;
            end
        end
    end

    // Line store: even and odd position banks
    logic [POS_W-1:0]   cr_pos;
    logic [BANK_AW-1:0] byte_addr;
    logic [BANK_AW-1:0] cr_addr;
    logic [POS_W-1:0]   rd_pos;
    logic               rd_in_range;
    logic               bank_we    [2];
    logic [BANK_AW-1:0] bank_waddr [2];
    logic [7:0]         bank_wdata [2];
    logic               bank_re;
    logic [BANK_AW-1:0] bank_raddr;
    logic [7:0]         bank_rdata [2];

    assign cr_pos      = idx_inc[POS_W-1:0];
    assign byte_addr   = {write_slot_reg, write_index_reg[POS_W-1:1]};
    assign cr_addr     = {write_slot_reg, cr_pos[POS_W-1:1]};
    assign rd_pos      = POS_W'(cmd.read_position);
    assign rd_in_range = (8'(cmd.read_slot) < 8'(SLOT_COUNT))
                         && (16'(cmd.read_position) <= 16'(LINE_BYTES));
    assign bank_re     = cmd_accept && is_read;
    assign bank_raddr  = {SLOT_W'(cmd.read_slot), rd_pos[POS_W-1:1]};

    always_comb
    begin
        for (int b = 0; b < 2; b++)
        begin
            if (clearing_reg)
            begin
                bank_we[b]    = 1'b1;
                bank_waddr[b] = clr_addr_reg;
                bank_wdata[b] = 8'd0;
            end
            else if (write_index_reg[0] == 1'(b))
            begin
                bank_we[b]    = cmd_accept && is_byte;
                bank_waddr[b] = byte_addr;
                bank_wdata[b] = cmd.data_byte;
            end
            else
            begin
                bank_we[b]    = cmd_accept && is_byte && append;
                bank_waddr[b] = cr_addr;
                bank_wdata[b] = CH_CR;
            end
        end
    end

    cld_ram #(
        .WIDTH (8),
        .DEPTH (BANK_D)
    ) u_bank_even (
        .clk   (clk),
        .we    (bank_we[0]),
        .waddr (bank_waddr[0]),
        .wdata (bank_wdata[0]),
        .re    (bank_re),
        .raddr (bank_raddr),
        .rdata (bank_rdata[0])
    );

    cld_ram #(
        .WIDTH (8),
        .DEPTH (BANK_D)
    ) u_bank_odd (
        .clk   (clk),
        .we    (bank_we[1]),
        .waddr (bank_waddr[1]),
        .wdata (bank_wdata[1]),
        .re    (bank_re),
        .raddr (bank_raddr),
        .rdata (bank_rdata[1])
    );

    // Result stage
    logic rsp_valid_reg, rsp_valid_next;
    rsp_t rsp_reg, rsp_next;
    logic rd_use_reg, rd_use_next;
    logic rd_bank_reg, rd_bank_next;

    always_comb
    begin
        rsp_next               = '0;
        rsp_next.pending_lines = queue_count_next;
        rsp_next.ready_out     = ready_flag_next;
        if (is_byte)
        begin
            rsp_next.slot          = 2'(write_slot_reg);
            rsp_next.position      = 8'(write_index_reg);
            rsp_next.line_complete = close;
            rsp_next.line_length   = close ? 8'(line_len) : 8'd0;
            rsp_next.echo_line     = echo;
        end
        rd_use_next  = is_read && rd_in_range;
        rd_bank_next = rd_pos[0];

        if (cmd_accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Hold the payload while stalled; the banks hold read data until the next read.
    always_ff @(posedge clk)
    begin
        if (cmd_accept)
        begin
            rsp_reg     <= rsp_next;
            rd_use_reg  <= rd_use_next;
            rd_bank_reg <= rd_bank_next;
        end
    end

    always_comb
    begin
        rsp           = rsp_reg;
        rsp.read_data = rd_use_reg ? (rd_bank_reg ? bank_rdata[1] : bank_rdata[0]) : 8'd0;
    end

    assign rsp_valid = rsp_valid_reg;

    `CLD_ASSERT_ALWAYS(a_index_in_range, 16'(write_index_reg) <= 16'(LINE_BYTES),
        "write index beyond line depth")
    `CLD_ASSERT_IMPLY(a_echo_on_close, rsp_valid && rsp.echo_line, rsp.line_complete,
        "echo flagged on a line that did not close")
    `CLD_ASSERT_IMPLY(a_clear_blocks_input, clearing_reg, cmd_stall,
        "item taken during clearing pass")

endmodule

`default_nettype wire
